### sv/ptb_pkg.sv
// ptb_pkg: shared constants and types for the periodic timer bank
// no dependencies
`timescale 1ns / 1ps
package ptb_pkg;
  localparam int TIMER_COUNT_DEF = 16;
  localparam int FIRE_LIMIT = 16;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;

  localparam logic [3:0] M_TICK   = 4'd0;
  localparam logic [3:0] M_ALLOC  = 4'd1;
  localparam logic [3:0] M_PERIOD = 4'd2;
  localparam logic [3:0] M_FREQ   = 4'd3;
  localparam logic [3:0] M_DIV    = 4'd4;
  localparam logic [3:0] M_START  = 4'd5;
  localparam logic [3:0] M_STOP   = 4'd6;
  localparam logic [3:0] M_REL    = 4'd7;
  localparam logic [3:0] M_STARTA = 4'd8;
  localparam logic [3:0] M_STOPA  = 4'd9;
  localparam logic [3:0] M_RELA   = 4'd10;
  localparam logic [3:0] M_USER   = 4'd11;
  localparam logic [3:0] M_WORST  = 4'd12;

  localparam logic [2:0] EV_DONE  = 3'd0;
  localparam logic [2:0] EV_FIRED = 3'd1;
  localparam logic [2:0] EV_ALLOC = 3'd2;
  localparam logic [2:0] EV_FAIL  = 3'd3;
  localparam logic [2:0] EV_USER  = 3'd4;
  localparam logic [2:0] EV_WORST = 3'd5;

  localparam logic [31:0] DEF_PERIOD = 32'd10000;
  localparam logic [31:0] PIT_ZERO   = 32'd54925;
  localparam logic [31:0] ONE_SEC_US = 32'd1000000;
  localparam logic [31:0] PIT_NUM    = 32'd10000;
  localparam logic [31:0] PIT_DEN    = 32'd11932;
  localparam logic [31:0] GAP_CLAMP  = 32'd100;
  localparam logic [9:0]  FLOOR_RST  = 10'd1;

  // ceil(PIT_NUM * 2^30 / PIT_DEN): exact for any 16-bit divisor
  localparam int PIT_SHIFT = 30;
  localparam logic [29:0] PIT_RECIP =
    30'(({32'd0, PIT_NUM} * (64'd1 << PIT_SHIFT) + {32'd0, PIT_DEN} - 64'd1) /
        {32'd0, PIT_DEN});

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic div_start; // start divider on prepared operands
    logic commit;    // write back result of the item
    logic slot_wr;   // write back quotient/remainder of scanned slot
    logic emit;      // present a result
    logic emit_last;
  } ptb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic running;   // scanned slot is running
    logic active;
  } ptb_sts_t;
endpackage

### sv/ptb_div.sv
// ptb_div: 64 by 32 bit restoring divider, one quotient bit per cycle
// depends on ptb_pkg
`timescale 1ns / 1ps
module ptb_div import ptb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [31:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] sh;

  assign sh = {r_r[31:0], q_r[63]};
  always_comb begin
    q_nxt = {q_r[62:0], 1'b0};
    r_nxt = sh;
    cnt_nxt = cnt_r - 7'd1;
    if (sh >= {1'b0, d_r}) begin
      r_nxt = sh - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'd64;
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (cnt_r != 0) begin
      cnt_r <= cnt_nxt;
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end
  assign busy = (cnt_r != 0);
  assign quot = q_r;
  assign rem = r_r[31:0];
endmodule

### sv/ptb_ctrl.sv
// ptb_ctrl: sequencer for one item at a time
// depends on ptb_pkg
`timescale 1ns / 1ps
module ptb_ctrl import ptb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [3:0]    in_mode,
  input  logic          out_busy,
  input  ptb_sts_t      sts,
  output ptb_cmd_t      cmd,
  output logic [IW-1:0] scan_idx
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_DIV = 3'd2,
                         S_SCAN = 3'd3, S_SDIV = 3'd4, S_EMIT = 3'd5, S_DONE = 3'd6;
  logic [2:0] st_r, st_nxt;
  logic [3:0] mode_r;
  logic [IW:0] idx_r, idx_nxt;
  logic [5:0] fired_r, fired_nxt;
  logic       div_seen_r, div_seen_nxt;

  assign scan_idx = idx_r[IW-1:0];
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    fired_nxt = fired_r;
    div_seen_nxt = div_seen_r;
    cmd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // frequency needs the divider
        if (mode_r == M_FREQ) begin
          cmd.div_start = 1'b1;
          div_seen_nxt = 1'b0;
          st_nxt = S_DIV;
        end else if (mode_r == M_TICK && sts.active) begin
          cmd.commit = 1'b1;
          idx_nxt = '0;
          fired_nxt = '0;
          st_nxt = S_SCAN;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_seen_r && !sts.div_busy) st_nxt = S_DONE;
        div_seen_nxt = 1'b1;
      end
      S_SCAN: begin
        if (idx_r == TIMER_COUNT[IW:0]) begin
          st_nxt = S_DONE;
        end else if (sts.running) begin
          cmd.div_start = 1'b1;
          div_seen_nxt = 1'b0;
          st_nxt = S_SDIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SDIV: begin
        div_seen_nxt = 1'b1;
        if (div_seen_r && !sts.div_busy) begin
          cmd.slot_wr = 1'b1;
          st_nxt = (fired_r < FIRE_LIMIT[5:0]) ? S_EMIT : S_SCAN;
          if (fired_r >= FIRE_LIMIT[5:0]) idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.emit = 1'b1;
          fired_nxt = fired_r + 6'd1;
          idx_nxt = idx_r + 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          if (mode_r != M_TICK) cmd.commit = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
      fired_r <= '0;
      div_seen_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      fired_r <= fired_nxt;
      div_seen_r <= div_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mode_r <= in_mode;
  end
endmodule

### sv/ptb_dp.sv
// ptb_dp: slot stores, tick bookkeeping and result register
// depends on ptb_pkg, ptb_div
`timescale 1ns / 1ps
module ptb_dp import ptb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [9:0]    cfg_wdata,
  input  logic [3:0]    in_mode,
  input  logic [4:0]    in_timer_index,
  input  logic [31:0]   in_now_ms,
  input  logic [31:0]   in_operand,
  input  ptb_cmd_t      cmd,
  input  logic [IW-1:0] scan_idx,
  output ptb_sts_t      sts,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_event_kind,
  output logic [3:0]    out_slot,
  output logic [16:0]   out_fire_count,
  output logic [31:0]   out_word,
  output logic          out_last
);
  logic [1:0]  status_r [TIMER_COUNT];
  logic [31:0] period_r [TIMER_COUNT];
  logic [31:0] acc_r    [TIMER_COUNT];
  logic [31:0] user_r   [TIMER_COUNT];
  logic        active_r, prev_valid_r;
  logic [31:0] prev_r, worst_r, diff_r;
  logic [9:0]  floor_r;
  logic [3:0]  mode_r;
  logic [31:0] op_r, now_r;
  logic        sel_ok_r;
  logic [IW-1:0] sel_r;
  logic [16:0] fire_cnt_r;

  logic        d_start, d_busy;
  logic [63:0] d_dvd, d_q;
  logic [31:0] d_dvs, d_rem;

  logic [31:0] gap, gap_sc;
  logic [IW-1:0] free_idx;
  logic        free_ok;
  logic [31:0] new_period;
  logic [31:0] cur_period;
  logic [32:0] sum;
  logic [45:0] pit_prod;

  assign gap = now_r - prev_r;
  assign gap_sc = ((gap > GAP_CLAMP) ? GAP_CLAMP : gap) * 32'd1000;
  assign cur_period = period_r[scan_idx];
  assign sum = {1'b0, acc_r[scan_idx]} + {1'b0, diff_r};
  // divisor to period by reciprocal multiply
  assign pit_prod = {30'd0, op_r[15:0]} * {16'd0, PIT_RECIP};

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (status_r[i] == ST_FREE) begin
        free_ok = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // divider operand select
  always_comb begin
    d_start = cmd.div_start;
    d_dvd = {31'd0, sum};
    d_dvs = (cur_period == 0) ? 32'hFFFF_FFFF : cur_period;
    if (mode_r == M_FREQ) begin
      d_dvd = {32'd0, ONE_SEC_US};
      d_dvs = (op_r == 0) ? 32'd1 : op_r;
    end
  end

  ptb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .dividend(d_dvd),
    .divisor(d_dvs), .busy(d_busy), .quot(d_q), .rem(d_rem)
  );

  always_comb begin
    new_period = op_r;
    if (mode_r == M_FREQ) new_period = (op_r == 0) ? 32'd0 : d_q[31:0];
    else if (mode_r == M_DIV)
      new_period = (op_r[15:0] == 0) ? PIT_ZERO : {16'd0, pit_prod[45:30]};
  end

  assign sts.div_busy = d_busy;
  assign sts.running = (status_r[scan_idx] == ST_RUNNING);
  assign sts.active = active_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      op_r <= in_operand;
      now_r <= in_now_ms;
      sel_ok_r <= !in_timer_index[4] && ({1'b0, in_timer_index[3:0]} < TIMER_COUNT);
      sel_r <= IW'(in_timer_index[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_RST;
    end else if (cfg_we) begin
      floor_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_r <= '0;
      worst_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        status_r[i] <= ST_FREE;
        user_r[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.commit) begin
        unique case (mode_r)
          M_TICK: begin
            diff_r <= prev_valid_r ? gap_sc : 32'd0;
            if (prev_valid_r && gap > worst_r) worst_r <= gap;
            prev_r <= now_r;
            prev_valid_r <= 1'b1;
          end
          M_ALLOC: begin
            active_r <= 1'b1;
            if (free_ok) begin
              status_r[free_idx] <= ST_STOPPED;
              period_r[free_idx] <= DEF_PERIOD;
              acc_r[free_idx] <= '0;
            end
          end
          M_PERIOD, M_FREQ, M_DIV: begin
            if (sel_ok_r) begin
              period_r[sel_r] <= new_period;
              acc_r[sel_r] <= '0;
            end
          end
          M_START: if (sel_ok_r && status_r[sel_r] == ST_STOPPED) status_r[sel_r] <= ST_RUNNING;
          M_STOP:  if (sel_ok_r && status_r[sel_r] == ST_RUNNING) status_r[sel_r] <= ST_STOPPED;
          M_REL:   if (sel_ok_r) status_r[sel_r] <= ST_FREE;
          M_STARTA: for (int i = 0; i < TIMER_COUNT; i++)
            if (status_r[i] == ST_STOPPED) status_r[i] <= ST_RUNNING;
          M_STOPA: for (int i = 0; i < TIMER_COUNT; i++)
            if (status_r[i] == ST_RUNNING) status_r[i] <= ST_STOPPED;
          M_RELA: for (int i = 0; i < TIMER_COUNT; i++) status_r[i] <= ST_FREE;
          M_USER:  if (sel_ok_r) user_r[sel_r] <= op_r;
          M_WORST: if (worst_r >= {22'd0, floor_r}) worst_r <= '0;
          default: ;
        endcase
      end
      if (cmd.slot_wr) begin
        if (cur_period == 0) begin
          acc_r[scan_idx] <= sum[31:0];
        end else begin
          acc_r[scan_idx] <= d_rem;
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
    end
  end

  // fire count waits here so a stalled result keeps its payload
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      fire_cnt_r <= (cur_period == 0) ? 17'd0 : d_q[16:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      out_event_kind <= EV_DONE;
      out_slot <= '0;
      out_word <= '0;
      if (!cmd.emit_last) begin
        out_event_kind <= EV_FIRED;
        out_slot <= 4'(scan_idx);
        out_fire_count <= fire_cnt_r;
        out_word <= user_r[scan_idx];
      end else begin
        out_fire_count <= '0;
        priority case (mode_r)
          M_ALLOC: begin
            out_event_kind <= free_ok ? EV_ALLOC : EV_FAIL;
            out_slot <= free_ok ? 4'(free_idx) : 4'd0;
          end
          M_USER: begin
            out_event_kind <= EV_USER;
            out_word <= sel_ok_r ? user_r[sel_r] : 32'd0;
          end
          M_WORST: begin
            out_event_kind <= EV_WORST;
            out_word <= (worst_r >= {22'd0, floor_r}) ? worst_r - {22'd0, floor_r} : 32'd0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

### sv/periodic_timer_bank_unit.sv
// periodic_timer_bank_unit: top level of the periodic timer bank
// depends on ptb_pkg, ptb_ctrl, ptb_dp, ptb_div
//
// Usage: items enter on in_valid/in_stall with mode, timer_index, now_ms and
// operand. One item is worked at a time; in_stall is high from the cycle after
// acceptance until the final result has been registered.
// Results leave on out_valid/out_stall from a single output register; each
// item ends with a result that has out_last set.
// Control and divisor items skip the divider; frequency items use the shared
// 64-step restoring divider, and a tick scans the slots and runs one divide
// per running slot.
// A stalled receiver holds the output register and the sequencer waits.
// Synchronous reset frees all slots, clears user words, the tick history and
// worst gap, and sets the floor register to 1. cfg_we writes the floor; the user
// must assert it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module periodic_timer_bank_unit import ptb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [4:0]  in_timer_index,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_slot,
  output logic [16:0] out_fire_count,
  output logic [31:0] out_word,
  output logic        out_last
);
  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  ptb_cmd_t cmd;
  ptb_sts_t sts;
  logic [IW-1:0] scan_idx;

  ptb_ctrl #(.TIMER_COUNT(TIMER_COUNT), .IW(IW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .out_busy(out_valid), .sts(sts), .cmd(cmd),
    .scan_idx(scan_idx)
  );

  ptb_dp #(.TIMER_COUNT(TIMER_COUNT), .IW(IW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mode(in_mode), .in_timer_index(in_timer_index), .in_now_ms(in_now_ms),
    .in_operand(in_operand), .cmd(cmd), .scan_idx(scan_idx), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_kind(out_event_kind),
    .out_slot(out_slot), .out_fire_count(out_fire_count), .out_word(out_word),
    .out_last(out_last)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid) else $error("result overwritten");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("item taken while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |=> !in_stall) else $error("sequencer not idle after last");
`endif
endmodule
